@@ rtl/lmrr_pkg.sv @@
// Shared constants, types and the row remap function for the LED matrix
// remap and refresh block. No dependencies.
`default_nettype none

package lmrr_pkg;

  localparam int NumMatrices = 8;
  localparam int MatrixSize  = 8;
  localparam int SlotW       = $clog2(MatrixSize);
  localparam int MatIdxW     = 3;
  localparam int MapW        = 48;
  localparam int FrameW      = 64;
  localparam int DigitW      = 4;
  localparam int ChainW      = 64;
  localparam int InTdataW    = 72;
  localparam int OutTdataW   = 72;
  localparam int CfgDataW    = 64;
  localparam int CfgAddrW    = 6;
  localparam int RowMapBase  = 24;

  localparam logic [MapW-1:0] MapReset = 48'd275730608604808;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Input tuser flag: what the transaction carries.
  localparam logic ModeStore   = 1'b0;
  localparam logic ModeRefresh = 1'b1;

  // Move each lit row of a column byte to its target row; MSB is row 0.
  function automatic logic [7:0] remap_rows(logic [MapW-1:0] map, logic [7:0] col);
    logic [7:0] digit;
    logic [2:0] target;
    digit = '0;
    for (int r = 0; r < MatrixSize; r++) begin
      target = map[RowMapBase + 3*r +: 3];
      if (col[7-r]) begin
        digit[~target] = 1'b1;
      end
    end
    return digit;
  endfunction

endpackage

`default_nettype wire

@@ rtl/led_matrix_remap_refresh.sv @@
// Top level: frame store, remap registers and refresh sequencer for a chain
// of 8x8 LED matrix drivers. Depends on lmrr_pkg.
//
// Usage:
//   Input stream (s_axis_*): tuser[0] = mode. A store transaction (mode 0)
//   writes eight column bytes for the matrix in tdata[2:0]; a store to a
//   matrix outside the chain is dropped. A refresh transaction (mode 1)
//   starts the sequencer, which emits eight results on m_axis_*, digit
//   registers 1..8 in order, tlast on the eighth.
//   The accepted refresh sets the sequencer state, which then loads the
//   output register; then one result per cycle while the receiver takes
//   them. s_axis_tready is low while the sequencer runs, so a refresh holds
//   the input until its last result is loaded; the rate is set by the single
//   slot unit, which builds one digit register (all matrices at once) per cycle when not stalled.
//   A stall on m_axis_tready holds the output register and the slot counter;
//   the sequencer resumes when the result is taken.
//   APB: 64-bit data, map_matrix_i at byte address 8*i, pready always high.
//   Write maps only while idle.
//   Reset: frame store cleared (all pixels off), maps set to identity,
//   sequencer idle, no result pending.
`default_nettype none

module led_matrix_remap_refresh (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // input stream
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] matrix_index, [66:3] column_bytes, [71:67] zero
  input  wire [lmrr_pkg::InTdataW-1:0]  s_axis_tdata,
  // [0] mode
  input  wire                           s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // [3:0] digit_register, [67:4] chain_bytes, [71:68] zero
  output logic [lmrr_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  // configuration
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [lmrr_pkg::CfgAddrW-1:0]  paddr,
  input  wire [lmrr_pkg::CfgDataW-1:0]  pwdata,
  output logic [lmrr_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import lmrr_pkg::*;

  logic [MapW-1:0]    map_q   [NumMatrices];
  logic [FrameW-1:0]  frame_q [NumMatrices];

  state_e             state_q, state_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic               load_out;
  logic               out_valid_q, out_valid_d;
  logic [DigitW-1:0]  out_digit_q;
  logic [ChainW-1:0]  out_chain_q;
  logic               out_last_q;
  logic [ChainW-1:0]  chain;
  logic               s_accept;
  logic [MatIdxW-1:0] in_mat;
  logic [FrameW-1:0]  in_cols;
  logic [2:0]         cfg_idx;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign in_mat   = s_axis_tdata[MatIdxW-1:0];
  assign in_cols  = s_axis_tdata[MatIdxW +: FrameW];
  assign cfg_idx  = paddr[CfgAddrW-1:3];

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = {{(CfgDataW-MapW){1'b0}}, map_q[cfg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NumMatrices; m++) begin
        map_q[m] <= MapReset;
      end
    end else if (psel && penable && pwrite && pready) begin
      map_q[cfg_idx] <= pwdata[MapW-1:0];
    end
  end

  // Frame store, one 64-bit row per matrix, column 0 in the top byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NumMatrices; m++) begin
        frame_q[m] <= '0;
      end
    end else if (s_accept && (s_axis_tuser == ModeStore)
                 && ({1'b0, in_mat} < (MatIdxW+1)'(NumMatrices))) begin
      frame_q[in_mat] <= in_cols;
    end
  end

  // Slot unit: one digit register for every matrix in the chain
  always_comb begin
    logic [7:0] sel;
    chain = '0;
    for (int m = 0; m < NumMatrices; m++) begin
      sel = '0;
      // higher column wins on duplicate targets
      for (int c = 0; c < MatrixSize; c++) begin
        if (map_q[m][3*c +: 3] == slot_q) begin
          sel = frame_q[m][FrameW-1-8*c -: 8];
        end
      end
      chain[8*m +: 8] = remap_rows(map_q[m], sel);
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    slot_d        = slot_q;
    load_out      = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (s_axis_tuser == ModeRefresh)) begin
          state_d = ST_RUN;
          slot_d  = '0;
        end
      end
      ST_RUN: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          slot_d   = slot_q + 1'b1;
          if (slot_q == SlotW'(MatrixSize-1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_digit_q <= DigitW'(slot_q) + DigitW'(1);
      out_chain_q <= chain;
      out_last_q  <= (slot_q == SlotW'(MatrixSize-1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW-DigitW-ChainW){1'b0}}, out_chain_q, out_digit_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ rtl/lmrr_checker.sv @@
// Port-level checker for led_matrix_remap_refresh and its bind statement.
// Depends on lmrr_pkg.
`default_nettype none

module lmrr_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire                            s_axis_tuser,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [lmrr_pkg::OutTdataW-1:0]  m_axis_tdata,
  input wire                            m_axis_tlast
);
  import lmrr_pkg::*;

  // A refresh transaction takes the input side busy.
  a_refresh_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ModeRefresh) |=> !s_axis_tready)
    else $error("input ready after refresh accept");

  // A store finishes in its own cycle.
  a_store_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ModeStore) |=> s_axis_tready)
    else $error("input stalled after store");

  // tlast marks digit register 8, and only it.
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[DigitW-1:0] == DigitW'(MatrixSize))))
    else $error("tlast does not match digit register");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind led_matrix_remap_refresh lmrr_checker u_lmrr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for led_matrix_remap_refresh: frame stores, refreshes and
// remap register writes, with results checked against a local predictor.
// Depends on lmrr_pkg and the block's RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmrr_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 12;
  localparam int LongHold      = 300;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic [ChainW-1:0] chain;
    logic              last;
  } digit_write_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CfgAddrW-1:0]  paddr;
  logic [CfgDataW-1:0]  pwdata;
  logic [CfgDataW-1:0]  prdata;
  logic                 pready;

  // predictor copy of the block state
  logic [7:0]      frame_bytes [NumMatrices][MatrixSize];
  logic [MapW-1:0] map_regs [NumMatrices];
  digit_write_t    pending_writes [$];
  digit_write_t    front_write;

  int error_count    = 0;
  int store_count    = 0;
  int refresh_count  = 0;
  int checked_writes = 0;
  int map_writes     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_left      = 0;

  led_matrix_remap_refresh dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("tb: mismatch on %s: want %h got %h at %0t", what, want, got, $realtime);
    error_count++;
  endtask

  // Row permutation of one column byte; bit 7 is row 0, target t lands on bit 7-t.
  function automatic logic [7:0] move_rows(logic [MapW-1:0] map, logic [7:0] col);
    logic [7:0] lit;
    logic [2:0] dst;
    lit = '0;
    for (int r = 0; r < MatrixSize; r++) begin
      if (col[7-r]) begin
        dst = map[RowMapBase + 3*r +: 3];
        lit[7-dst] = 1'b1;
      end
    end
    return lit;
  endfunction

  task automatic predict_item(logic mode, logic [MatIdxW-1:0] idx, logic [FrameW-1:0] bytes);
    logic [7:0]   slot_bytes [MatrixSize][NumMatrices];
    logic [2:0]   slot;
    digit_write_t w;
    if (mode == ModeStore) begin
      for (int c = 0; c < MatrixSize; c++) begin
        frame_bytes[idx][c] = bytes[63 - 8*c -: 8];
      end
      store_count++;
    end else begin
      for (int s = 0; s < MatrixSize; s++) begin
        for (int m = 0; m < NumMatrices; m++) begin
          slot_bytes[s][m] = '0;
        end
      end
      // ascending column order: a later column overwrites a shared slot
      for (int m = 0; m < NumMatrices; m++) begin
        for (int c = 0; c < MatrixSize; c++) begin
          slot = map_regs[m][3*c +: 3];
          slot_bytes[slot][m] = move_rows(map_regs[m], frame_bytes[m][c]);
        end
      end
      for (int s = 0; s < MatrixSize; s++) begin
        w.digit = DigitW'(s + 1);
        w.chain = '0;
        for (int m = 0; m < NumMatrices; m++) begin
          w.chain[8*m +: 8] = slot_bytes[s][m];
        end
        w.last = (s == MatrixSize - 1);
        pending_writes.push_back(w);
      end
      refresh_count++;
    end
  endtask

  task automatic send_item(logic mode, logic [MatIdxW-1:0] idx, logic [FrameW-1:0] bytes);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, bytes, idx};
    s_axis_tuser  = mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(mode, idx, bytes);
  endtask

  // Stop offering, wait out every expected result, then let the block settle.
  task automatic finish_burst();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_map(int index, logic [MapW-1:0] value);
    logic [15:0] junk;
    junk = 16'($urandom);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CfgAddrW'(index * 8);
    pwdata  = {junk, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    map_regs[index] = value;
    map_writes++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_map(int index);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = CfgAddrW'(index * 8);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'h0, map_regs[index]}) begin
      report_mismatch($sformatf("map %0d readback", index), {16'h0, map_regs[index]}, prdata);
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [MapW-1:0] random_map();
    int perm [2][MatrixSize];
    int j;
    int t;
    logic [MapW-1:0] map;
    if ($urandom_range(1) == 0) begin
      return MapW'({$urandom, $urandom});
    end
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < MatrixSize; i++) perm[k][i] = i;
      for (int i = MatrixSize - 1; i > 0; i--) begin
        j = $urandom_range(i);
        t = perm[k][i];
        perm[k][i] = perm[k][j];
        perm[k][j] = t;
      end
    end
    for (int i = 0; i < MatrixSize; i++) begin
      map[3*i +: 3]              = 3'(perm[0][i]);
      map[RowMapBase + 3*i +: 3] = 3'(perm[1][i]);
    end
    return map;
  endfunction

  // 0: random, 1: mix of all-zero, all-one, identity and random maps
  task automatic load_maps(int flavor);
    logic [MapW-1:0] value;
    for (int m = 0; m < NumMatrices; m++) begin
      value = random_map();
      if (flavor == 1) begin
        case ($urandom_range(3))
          0: value = '0;
          1: value = '1;
          2: value = MapReset;
          default: ;
        endcase
      end
      write_map(m, value);
    end
  endtask

  task automatic test_reset_values();
    for (int m = 0; m < NumMatrices; m++) check_map(m);
    send_item(ModeRefresh, '0, '0);
    finish_burst();
  endtask

  task automatic test_store_extremes();
    send_item(ModeStore, 3'd0, '1);
    send_item(ModeStore, 3'd7, 64'h8000_0000_0000_0001);
    send_item(ModeStore, 3'd3, 64'hAA55_AA55_F00F_0FF0);
    send_item(ModeRefresh, '1, '1);
    send_item(ModeStore, 3'd0, '0);
    send_item(ModeRefresh, '0, '0);
    finish_burst();
  endtask

  task automatic test_remap_special_cases();
    logic [MapW-1:0] rev;
    for (int i = 0; i < MatrixSize; i++) begin
      rev[3*i +: 3]              = 3'(7 - i);
      rev[RowMapBase + 3*i +: 3] = 3'(7 - i);
    end
    // every column on slot 0: the highest column wins, other slots read zero
    write_map(0, {MapReset[47:24], 24'h0});
    // every row onto row 3: lit rows OR together
    write_map(1, {{8{3'd3}}, MapReset[23:0]});
    write_map(2, '0);
    write_map(3, '1);
    write_map(4, rev);
    for (int m = 5; m < NumMatrices; m++) write_map(m, random_map());
    for (int m = 0; m < NumMatrices; m++) check_map(m);
    send_item(ModeStore, 3'd0, 64'h0102_0408_1020_4080);
    send_item(ModeStore, 3'd1, 64'h8100_4200_2400_1800);
    send_item(ModeStore, 3'd2, 64'hFF00_0000_0000_00FF);
    send_item(ModeStore, 3'd3, 64'h1122_3344_5566_7788);
    send_item(ModeStore, 3'd4, 64'h8040_2010_0804_0201);
    send_item(ModeStore, 3'd5, 64'hDEAD_BEEF_0123_4567);
    send_item(ModeStore, 3'd6, 64'h00FF_00FF_00FF_00FF);
    send_item(ModeStore, 3'd7, 64'hF0E1_D2C3_B4A5_9687);
    send_item(ModeRefresh, 3'd5, 64'h5555_AAAA_5555_AAAA);
    finish_burst();
  endtask

  task automatic test_random_traffic(int n, int s_pct, int r_pct);
    logic [FrameW-1:0] bytes;
    int pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) begin
      pick  = $urandom_range(99);
      bytes = {$urandom, $urandom};
      if (pick < 8) bytes = '0;
      else if (pick < 16) bytes = '1;
      // refreshes carry junk in the ignored fields
      if ($urandom_range(99) < 62) send_item(ModeStore, 3'($urandom_range(7)), bytes);
      else send_item(ModeRefresh, 3'($urandom), bytes);
    end
    finish_burst();
  endtask

  // Receiver holds off while the sender keeps pushing refreshes.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_left = LongHold;
    repeat (5) begin
      send_item(ModeRefresh, '0, '0);
      send_item(ModeStore, 3'($urandom_range(7)), {$urandom, $urandom});
    end
    finish_burst();
  endtask

  // sample results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected result", 64'(m_axis_tdata[3:0]), m_axis_tdata[67:4]);
      end else begin
        front_write = pending_writes.pop_front();
        if (m_axis_tdata[3:0] !== front_write.digit)
          report_mismatch("digit_register", 64'(front_write.digit), 64'(m_axis_tdata[3:0]));
        if (m_axis_tdata[67:4] !== front_write.chain)
          report_mismatch("chain_bytes", front_write.chain, m_axis_tdata[67:4]);
        if (m_axis_tlast !== front_write.last)
          report_mismatch("tlast", 64'(front_write.last), 64'(m_axis_tlast));
        checked_writes++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb: timeout with %0d results outstanding", pending_writes.size());
    $display("tb: errors");
    $finish;
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ModeStore;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    for (int m = 0; m < NumMatrices; m++) begin
      map_regs[m] = MapReset;
      for (int c = 0; c < MatrixSize; c++) frame_bytes[m][c] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_store_extremes();
    test_remap_special_cases();
    load_maps(0);
    test_random_traffic(140, 17, 86);
    load_maps(1);
    test_random_traffic(140, 86, 17);
    load_maps(0);
    test_random_traffic(150, 0, 0);
    test_output_backpressure();

    if (pending_writes.size() != 0) begin
      report_mismatch("results never delivered", 64'(pending_writes.size()), 64'd0);
    end
    $display("tb: %0d stores, %0d refreshes, %0d digit writes checked, %0d map writes",
             store_count, refresh_count, checked_writes, map_writes);
    $display("tb: covered identity, degenerate and random remaps, three idle mixes, long stall");
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
